// ===== hdl/irt_pkg.sv =====
// irt_pkg: shared constants, operation codes and result codes
// for the interval reservation table; no dependencies
package irt_pkg;

	// default sizes
	localparam int NUM_ROWS_DEF    = 256;
	localparam int NUM_ENTRIES_DEF = 64;
	localparam int SEAT_BITS_DEF   = 10;
	localparam int OWNER_BITS_DEF  = 16;

	// fixed field widths
	localparam int ROW_W    = 8;
	localparam int STATUS_W = 3;

	// operation codes
	localparam logic OP_RESERVE = 1'b0;
	localparam logic OP_LOOKUP  = 1'b1;

	// result codes
	localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

endpackage

// ===== hdl/interval_reservation_table.sv =====
// interval_reservation_table: table of reserved seat ranges with overlap check
// and owner lookup, one comparator scanning an entry memory
// depends on irt_pkg
//
//   channel   signals                                              direction
//   command   start, busy, operation, row_index, start_seat,       in (busy out)
//             end_seat, owner_id, query_seat
//   result    done, status, found_owner                            out
//
// an item is taken when start is high and busy is low; it then scans the
// n stored entries (at most NUM_ENTRIES) one at a time through the single
// entry-memory read port feeding one comparator, then finishes.
// the scan stops at the first matching entry; an empty table or a row out of
// range skips the scan and goes straight to the finish step.
// the result shows for one cycle with done high; the receiver cannot stall,
// and busy is already low in that cycle.
// reset empties the table at once through the entry count; no clearing pass.
module interval_reservation_table #(
	parameter int NUM_ROWS    = irt_pkg::NUM_ROWS_DEF,
	parameter int NUM_ENTRIES = irt_pkg::NUM_ENTRIES_DEF,
	parameter int SEAT_BITS   = irt_pkg::SEAT_BITS_DEF,
	parameter int OWNER_BITS  = irt_pkg::OWNER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [irt_pkg::ROW_W-1:0]     row_index,
	input  logic [SEAT_BITS-1:0]          start_seat,
	input  logic [SEAT_BITS-1:0]          end_seat,
	input  logic [OWNER_BITS-1:0]         owner_id,
	input  logic [SEAT_BITS-1:0]          query_seat,
	output logic                          done,
	output logic [irt_pkg::STATUS_W-1:0]  status,
	output logic [OWNER_BITS-1:0]         found_owner
);
	import irt_pkg::*;

	localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(NUM_ENTRIES);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	typedef struct packed {
		logic [ROW_W-1:0]      row;
		logic [SEAT_BITS-1:0]  first;
		logic [SEAT_BITS-1:0]  last;
		logic [OWNER_BITS-1:0] owner;
	} entry_t;

	logic [1:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         issue_idx_q;
	logic                  cmp_valid_q;
	logic                  cmp_last_q;
	logic                  hit_q;
	logic                  op_q;
	logic                  row_bad_q;
	logic [ROW_W-1:0]      row_q;
	logic [SEAT_BITS-1:0]  first_q;
	logic [SEAT_BITS-1:0]  last_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [SEAT_BITS-1:0]  query_q;
	logic [OWNER_BITS-1:0] hit_owner_q;
	entry_t                mem [NUM_ENTRIES];
	entry_t                rd_data_q;
	entry_t                wr_entry;
	logic                  accept;
	logic                  row_bad;
	logic                  hit;
	logic                  do_write;
	logic [STATUS_W-1:0]   fin_status;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign row_bad = (32'(row_index) >= NUM_ROWS);

	// shared comparator: clash test for reserves, containment for lookups
	always_comb begin
		hit = 1'b0;
		if (rd_data_q.row == row_q) begin
			if (op_q == OP_RESERVE) begin
				hit = (rd_data_q.first >= first_q && rd_data_q.first <= last_q) ||
				      (first_q >= rd_data_q.first && first_q <= rd_data_q.last);
			end else begin
				hit = (query_q >= rd_data_q.first) && (query_q <= rd_data_q.last);
			end
		end
	end

	// final decision for the item
	always_comb begin
		do_write   = 1'b0;
		fin_status = ST_NONE;
		if (op_q == OP_RESERVE) begin
			if (row_bad_q) begin
				fin_status = ST_FULL;
			end else if (hit_q) begin
				fin_status = ST_OVERLAP;
			end else if (count_q == COUNT_MAX) begin
				fin_status = ST_FULL;
			end else begin
				fin_status = ST_RESERVED;
				do_write   = 1'b1;
			end
		end else begin
			fin_status = (!row_bad_q && hit_q) ? ST_FOUND : ST_NONE;
		end
	end

	assign wr_entry = '{row: row_q, first: first_q, last: last_q, owner: owner_q};

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && do_write) begin
			mem[count_q[AW-1:0]] <= wr_entry;
		end
		rd_data_q <= mem[issue_idx_q];
	end

	// latched item fields and the owner of the matching entry
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= operation;
			row_bad_q <= row_bad;
			row_q     <= row_index;
			first_q   <= start_seat;
			last_q    <= end_seat;
			owner_q   <= owner_id;
			query_q   <= query_seat;
		end
		if (state_q == S_SCAN && cmp_valid_q && hit) begin
			hit_owner_q <= rd_data_q.owner;
		end
	end

	// sequencer: accept, scan entries, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			issue_idx_q <= '0;
			cmp_valid_q <= 1'b0;
			cmp_last_q  <= 1'b0;
			hit_q       <= 1'b0;
			done        <= 1'b0;
			status      <= ST_NONE;
			found_owner <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						issue_idx_q <= '0;
						cmp_valid_q <= 1'b0;
						cmp_last_q  <= 1'b0;
						hit_q       <= 1'b0;
						state_q     <= (count_q == '0 || row_bad) ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmp_valid_q && hit) begin
						hit_q   <= 1'b1;
						state_q <= S_FINISH;
					end else if (cmp_valid_q && cmp_last_q) begin
						state_q <= S_FINISH;
					end else if (!cmp_last_q) begin
						cmp_valid_q <= 1'b1;
						cmp_last_q  <= (CW'(issue_idx_q) == count_q - CW'(1));
						issue_idx_q <= issue_idx_q + AW'(1);
					end
				end
				S_FINISH: begin
					done        <= 1'b1;
					status      <= fin_status;
					found_owner <= (fin_status == ST_FOUND) ? hit_owner_q : '0;
					if (do_write) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the table never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("entry count above table depth");

	// a result appears right after every finish step
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |=> done)
		else $error("finish step gave no result");

	// an owner is reported only with a found status
	a_owner_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_FOUND) |-> (found_owner == '0))
		else $error("owner reported without a match");

	// the table grows only with a reserved result
	a_count_grows_on_reserve: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && count_q != COUNT_MAX) |=>
		((count_q != $past(count_q)) == (status == ST_RESERVED)))
		else $error("entry count changed without a reserved result");

endmodule
